/* sv/first_fit_pool_allocator_macros.svh */
// Assertion helpers used by the checker file.
`ifndef FIRST_FIT_POOL_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_POOL_ALLOCATOR_MACROS_SVH

// A property sampled on the rising clock edge, switched off during reset.
`define FFPA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("first fit pool allocator check failed");

// A condition that must hold at every sampled edge outside reset.
`define FFPA_ALWAYS(label, cond) \
    `FFPA_ASSERT(label, 1'b1 |-> (cond))

`endif

/* sv/ffpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ffpa_pkg;

    localparam int FIELD_W = 16;
    localparam int CAND_W  = FIELD_W + 1;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;
    localparam logic [1:0] CMD_REMOVE = 2'd3;

    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_NO_GAP = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;
    localparam logic [1:0] STATUS_MISS   = 2'd3;

    localparam logic [CAND_W-1:0] ADDR_TOP = {1'b0, {FIELD_W{1'b1}}};

    typedef struct packed {
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
        logic [FIELD_W-1:0] id;
    } entry_t;

    // Probe that walks the chain, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic [1:0]         cmd;
        logic [CAND_W-1:0]  cand;
        logic [FIELD_W-1:0] want;
        logic [FIELD_W-1:0] key;
        logic               found;
        entry_t             res;
    } token_t;

    // Table update broadcast to every cell at the end of a scan.
    typedef struct packed {
        logic   insert;
        logic   drop;
        logic   found;
        entry_t fresh;
    } commit_t;

endpackage
`default_nettype wire

/* sv/first_fit_pool_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// First-fit allocator over one address pool, holding up to MAX_BLOCKS blocks in
// ascending start order, one block per cell of a chain. A request is taken when
// the block is idle and no result waits; its probe then walks the chain one cell
// per cycle, and the table is shifted in place as the result is registered. A
// new request is taken only after that result has been passed on, and an
// allocate against a full table answers without a scan. The pool registers sit
// on the APB port at byte addresses 0 and 4 and must be written while idle.
module first_fit_pool_allocator #(
    parameter int MAX_BLOCKS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire [1:0]   command,
    input  wire [15:0]  request_size,
    input  wire [15:0]  release_address,
    input  wire [15:0]  block_ident,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [1:0]  status,
    output logic [15:0] result_start,
    output logic [15:0] result_size,
    output logic [15:0] result_id
);
    import ffpa_pkg::*;

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                state_reg, state_next;
    logic [FIELD_W-1:0]  pool_base_reg, pool_length_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [FIELD_W-1:0]  next_ident_reg, next_ident_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          status_reg, status_next;
    entry_t              out_reg, out_next;
    token_t              launch_reg, launch_next;

    token_t  tok [MAX_BLOCKS+1];
    entry_t  ent [MAX_BLOCKS];
    commit_t commit;

    logic              accept;
    logic              full;
    logic              cfg_write;
    logic [CAND_W-1:0] pool_end;
    logic              fits;
    token_t            ex;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = paddr[2] ? {16'd0, pool_length_reg} : {16'd0, pool_base_reg};

    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign full     = count_reg == CW'(MAX_BLOCKS);
    assign ex       = tok[MAX_BLOCKS];
    assign tok[0]   = launch_reg;

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++)
        begin : g_cell
            ffpa_cell #(
                .IDX(g),
                .CW (CW)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .count     (count_reg),
                .tin       (tok[g]),
                .tout      (tok[g+1]),
                .prev_entry(ent[(g == 0) ? 0 : g-1]),
                .next_entry(ent[(g == MAX_BLOCKS-1) ? g : g+1]),
                .entry     (ent[g]),
                .commit    (commit)
            );
        end
    endgenerate

    always_comb
    begin
        pool_end = {1'b0, pool_base_reg} + {1'b0, pool_length_reg};
        if (pool_end > ADDR_TOP)
        begin
            pool_end = ADDR_TOP;
        end
        fits = !(ex.cand > pool_end) && ({1'b0, ex.want} <= pool_end - ex.cand);

        state_next      = state_reg;
        count_next      = count_reg;
        next_ident_next = next_ident_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        out_next        = out_reg;
        commit          = '0;
        commit.found    = ex.found;
        commit.fresh    = '{start: ex.cand[FIELD_W-1:0], len: ex.want, id: next_ident_reg};

        launch_next       = '0;
        launch_next.cmd   = command;
        launch_next.cand  = {1'b0, pool_base_reg};
        launch_next.want  = request_size;
        launch_next.key   = (command == CMD_FREE) ? release_address : block_ident;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_ALLOC && full)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = STATUS_FULL;
                        out_next       = '0;
                    end
                    else
                    begin
                        launch_next.valid = 1'b1;
                        state_next        = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (ex.valid)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (ex.cmd == CMD_ALLOC)
                    begin
                        if (ex.found || fits)
                        begin
                            commit.insert   = 1'b1;
                            count_next      = count_reg + 1'b1;
                            next_ident_next = next_ident_reg + 1'b1;
                            status_next     = STATUS_DONE;
                            out_next        = commit.fresh;
                        end
                        else
                        begin
                            status_next = STATUS_NO_GAP;
                            out_next    = '0;
                        end
                    end
                    else if (ex.found)
                    begin
                        status_next = STATUS_DONE;
                        out_next    = ex.res;
                        if (ex.cmd != CMD_FIND)
                        begin
                            commit.drop = 1'b1;
                            count_next  = count_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        status_next = STATUS_MISS;
                        out_next    = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pool_base_reg   <= '0;
            pool_length_reg <= '0;
            count_reg       <= '0;
            next_ident_reg  <= '0;
            out_valid_reg   <= 1'b0;
            launch_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            next_ident_reg <= next_ident_next;
            out_valid_reg  <= out_valid_next;
            launch_reg     <= launch_next;
            if (cfg_write)
            begin
                if (paddr[2])
                begin
                    pool_length_reg <= pwdata[FIELD_W-1:0];
                end
                else
                begin
                    pool_base_reg <= pwdata[FIELD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_start = out_reg.start;
    assign result_size  = out_reg.len;
    assign result_id    = out_reg.id;

endmodule
`default_nettype wire

/* sv/ffpa_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module ffpa_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire [CW-1:0]         count,
    input  ffpa_pkg::token_t     tin,
    output ffpa_pkg::token_t     tout,
    input  ffpa_pkg::entry_t     prev_entry,
    input  ffpa_pkg::entry_t     next_entry,
    output ffpa_pkg::entry_t     entry,
    input  ffpa_pkg::commit_t    commit
);
    import ffpa_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    token_t tout_reg;
    token_t tout_next;
    logic   mark_reg;
    logic   mark_next;
    logic   after_reg;
    logic   after_next;

    logic              live;
    logic              at_end;
    logic              hit;
    logic [CAND_W-1:0] es;
    logic [CAND_W-1:0] ee;

    assign live   = CW'(IDX) < count;
    assign at_end = CW'(IDX) == count;
    assign es     = {1'b0, entry_reg.start};
    assign ee     = es + {1'b0, entry_reg.len};

    always_comb
    begin
        case (tin.cmd)
            CMD_ALLOC:
            begin
                hit = (es >= tin.cand) && ({1'b0, tin.want} <= es - tin.cand);
            end
            CMD_FREE:
            begin
                hit = entry_reg.start == tin.key;
            end
            default:
            begin
                hit = entry_reg.id == tin.key;
            end
        endcase
        hit = hit && live && !tin.found && tin.valid;

        tout_next = tin;
        if (hit)
        begin
            tout_next.found = 1'b1;
            tout_next.res   = entry_reg;
        end
        else if (tin.cmd == CMD_ALLOC && live && !tin.found && ee > tin.cand)
        begin
            tout_next.cand = ee;
        end

        mark_next  = tin.valid ? hit : mark_reg;
        after_next = tin.valid ? tin.found : after_reg;

        entry_next = entry_reg;
        if (commit.insert)
        begin
            if (commit.found && after_reg)
            begin
                entry_next = prev_entry;
            end
            else if ((commit.found && mark_reg) || (!commit.found && at_end))
            begin
                entry_next = commit.fresh;
            end
        end
        else if (commit.drop && (mark_reg || after_reg))
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tout_reg  <= '0;
            mark_reg  <= 1'b0;
            after_reg <= 1'b0;
        end
        else
        begin
            tout_reg  <= tout_next;
            mark_reg  <= mark_next;
            after_reg <= after_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign tout  = tout_reg;
    assign entry = entry_reg;

endmodule
`default_nettype wire

/* sv/ffpa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_pool_allocator_macros.svh"
module ffpa_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_stall,
    input wire        out_valid,
    input wire        out_stall,
    input wire [1:0]  status,
    input wire [15:0] result_start,
    input wire [15:0] result_size,
    input wire [15:0] result_id
);
    import ffpa_pkg::*;

    logic [47:0] result_bits;

    assign result_bits = {result_start, result_size, result_id};

    `FFPA_ASSERT(a_out_holds, out_valid && out_stall |=> out_valid)

    // A failed request reports an all-zero block.
    `FFPA_ASSERT(a_fail_zero, out_valid && status != STATUS_DONE |-> result_bits == 48'd0)

    // Only one request is in flight: nothing enters while a result waits.
    `FFPA_ALWAYS(a_one_at_a_time, !out_valid || in_stall)

    `FFPA_ASSERT(a_busy_after_take, in_valid && !in_stall |=> in_stall)

endmodule

bind first_fit_pool_allocator ffpa_checker u_ffpa_checker (.*);
`default_nettype wire

/* sim/tb_first_fit_pool_allocator.sv */
`timescale 1ns / 1ps
module tb_first_fit_pool_allocator;
    import ffpa_pkg::*;

    localparam int TABLE_DEPTH = 16;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] start;
        logic [15:0] size;
        logic [15:0] id;
    } alloc_answer_t;

    class alloc_scoreboard;
        int unsigned   pool_base;
        int unsigned   pool_length;
        int unsigned   blk_start [TABLE_DEPTH];
        int unsigned   blk_len [TABLE_DEPTH];
        int unsigned   blk_id [TABLE_DEPTH];
        int            blk_count;
        int unsigned   next_id;
        alloc_answer_t answers [$];
        int            failures;

        function new();
            pool_base = 0;
            pool_length = 0;
            blk_count = 0;
            next_id = 0;
            failures = 0;
        endfunction

        function void set_pool(int unsigned base, int unsigned length);
            pool_base = base;
            pool_length = length;
        endfunction

        function int pending();
            return answers.size();
        endfunction

        // Start or id of a live block, used to aim frees, finds and removes at real entries.
        function int unsigned live_start();
            return blk_start[$urandom_range(blk_count - 1, 0)];
        endfunction

        function int unsigned live_id();
            return blk_id[$urandom_range(blk_count - 1, 0)];
        endfunction

        function void drop_block(int pos);
            for (int i = pos; i + 1 < blk_count; i++)
            begin
                blk_start[i] = blk_start[i + 1];
                blk_len[i] = blk_len[i + 1];
                blk_id[i] = blk_id[i + 1];
            end
            blk_count--;
        endfunction

        function alloc_answer_t predict_alloc(int unsigned want);
            alloc_answer_t r;
            int unsigned cand;
            int unsigned pool_end;
            int unsigned es;
            int unsigned ee;
            int pos;
            r = '{STATUS_DONE, 16'd0, 16'd0, 16'd0};
            cand = pool_base;
            pool_end = pool_base + pool_length;
            pos = -1;
            if (pool_end > 65535)
                pool_end = 65535;
            if (blk_count >= TABLE_DEPTH)
            begin
                r.status = STATUS_FULL;
                return r;
            end
            for (int i = 0; i < blk_count; i++)
            begin
                es = blk_start[i];
                ee = es + blk_len[i];
                if (es >= cand && want <= es - cand)
                begin
                    pos = i;
                    break;
                end
                if (ee > cand)
                    cand = ee;
            end
            if (pos < 0)
            begin
                if (cand > pool_end || want > pool_end - cand)
                begin
                    r.status = STATUS_NO_GAP;
                    return r;
                end
                pos = blk_count;
            end
            for (int i = blk_count; i > pos; i--)
            begin
                blk_start[i] = blk_start[i - 1];
                blk_len[i] = blk_len[i - 1];
                blk_id[i] = blk_id[i - 1];
            end
            blk_start[pos] = cand & 16'hFFFF;
            blk_len[pos] = want;
            blk_id[pos] = next_id;
            blk_count++;
            r.start = cand[15:0];
            r.size = want[15:0];
            r.id = next_id[15:0];
            next_id = (next_id + 1) & 16'hFFFF;
            return r;
        endfunction

        function void note_request(logic [1:0] cmd, logic [15:0] want, logic [15:0] addr,
                                   logic [15:0] ident);
            alloc_answer_t r;
            bit hit;
            r = '{STATUS_MISS, 16'd0, 16'd0, 16'd0};
            if (cmd == CMD_ALLOC)
                r = predict_alloc(want);
            else
            begin
                for (int i = 0; i < blk_count; i++)
                begin
                    hit = (cmd == CMD_FREE) ? (blk_start[i] == addr) : (blk_id[i] == ident);
                    if (hit)
                    begin
                        r = '{STATUS_DONE, blk_start[i][15:0], blk_len[i][15:0],
                              blk_id[i][15:0]};
                        if (cmd != CMD_FIND)
                            drop_block(i);
                        break;
                    end
                end
            end
            answers.insert(answers.size(), r);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            failures++;
        endtask

        task check_result(logic [1:0] st, logic [15:0] s, logic [15:0] l, logic [15:0] id);
            alloc_answer_t e;
            if (answers.size() == 0)
            begin
                report($sformatf("unexpected result status %0d start %h", st, s));
                return;
            end
            e = answers.pop_front();
            if (st !== e.status)
                report($sformatf("status %0d, expected %0d", st, e.status));
            if (s !== e.start)
                report($sformatf("result_start %h, expected %h", s, e.start));
            if (l !== e.size)
                report($sformatf("result_size %h, expected %h", l, e.size));
            if (id !== e.id)
                report($sformatf("result_id %h, expected %h", id, e.id));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [15:0] request_size;
    logic [15:0] release_address;
    logic [15:0] block_ident;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [15:0] result_start;
    logic [15:0] result_size;
    logic [15:0] result_id;

    alloc_scoreboard sb;
    int transfers_in;
    int burst_left;
    bit gaps_on;
    int hold_cycles;
    bit hold_done;
    int stall_mode;

    first_fit_pool_allocator i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .request_size    (request_size),
        .release_address (release_address),
        .block_ident     (block_ident),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .result_start    (result_start),
        .result_size     (result_size),
        .result_id       (result_id)
    );

    always #5 clk = ~clk;

    // Receiver stall pattern; once the input side has moved 400 transfers it holds
    // off for a long stretch so the block backs up and stalls its input.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (!hold_done && transfers_in >= 400)
        begin
            hold_done <= 1'b1;
            hold_cycles <= 300;
            out_stall <= 1'b1;
        end
        else
        begin
            if ($urandom_range(199, 0) == 0)
                stall_mode <= $urandom_range(2, 0);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(99, 0) < 30);
                default: out_stall <= ($urandom_range(99, 0) < 75);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, result_start, result_size, result_id);
    end

    task send_item(logic [1:0] cmd, logic [15:0] want, logic [15:0] addr, logic [15:0] ident);
        int gap;
        in_valid <= 1'b1;
        command <= cmd;
        request_size <= want;
        release_address <= addr;
        block_ident <= ident;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(cmd, want, addr, ident);
        transfers_in++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(20, 1);
            gap = gaps_on ? $urandom_range(8, 1) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task write_reg(logic [2:0] addr, logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task set_pool(logic [15:0] base, logic [15:0] length);
        drain();
        write_reg(3'd0, base);
        write_reg(3'd4, length);
        sb.set_pool(base, length);
        @(posedge clk);
    endtask

    task random_item();
        int pick;
        logic [15:0] want;
        logic [15:0] addr;
        logic [15:0] ident;
        pick = $urandom_range(99, 0);
        want = 16'($urandom());
        addr = 16'($urandom());
        ident = 16'($urandom());
        if (pick < 45)
        begin
            case ($urandom_range(9, 0))
                0: want = 16'd0;
                1: want = 16'hFFFF;
                2, 3: ;
                default: want = 16'($urandom_range(sb.pool_length / 6 + 1, 1));
            endcase
            send_item(CMD_ALLOC, want, addr, ident);
        end
        else
        begin
            if (sb.blk_count > 0 && $urandom_range(9, 0) < 7)
            begin
                addr = 16'(sb.live_start());
                ident = 16'(sb.live_id());
            end
            if (pick < 70)
                send_item(CMD_FREE, want, addr, ident);
            else if (pick < 82)
                send_item(CMD_FIND, want, addr, ident);
            else
                send_item(CMD_REMOVE, want, addr, ident);
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        command = CMD_ALLOC;
        request_size = '0;
        release_address = '0;
        block_ident = '0;
        out_stall = 1'b0;
        transfers_in = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        hold_cycles = 0;
        hold_done = 1'b0;
        stall_mode = 0;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An empty pool only fits a zero-size block.
        send_item(CMD_ALLOC, 16'd1, 16'd0, 16'd0);
        send_item(CMD_ALLOC, 16'd0, 16'd0, 16'd0);
        send_item(CMD_FREE, 16'd0, 16'd0, 16'd0);
        set_pool(16'h1000, 16'h0100);
        send_item(CMD_ALLOC, 16'hFFFF, 16'd0, 16'd0);
        for (int i = 0; i < 16; i++)
            send_item(CMD_ALLOC, 16'h0010, 16'd0, 16'd0);
        send_item(CMD_ALLOC, 16'd0, 16'd0, 16'd0);
        send_item(CMD_FIND, 16'd0, 16'd0, 16'd3);
        send_item(CMD_REMOVE, 16'd0, 16'd0, 16'd4);
        send_item(CMD_FREE, 16'd0, 16'h1020, 16'd0);
        send_item(CMD_FREE, 16'd0, 16'hFFFF, 16'd0);
        send_item(CMD_FIND, 16'd0, 16'd0, 16'hFFFF);
        send_item(CMD_REMOVE, 16'd0, 16'd0, 16'd4);
        send_item(CMD_ALLOC, 16'h0008, 16'd0, 16'd0);

        // Random phases; the table stays live across pool changes.
        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0: set_pool(16'h0000, 16'hFFFF);
                1: set_pool(16'hFFFF, 16'hFFFF);
                2: set_pool(16'hFF00, 16'h0400);
                3: set_pool(16'h0000, 16'h0000);
                4: set_pool(16'h0800, 16'h0040);
                default: set_pool(16'($urandom()), 16'($urandom_range(16'h2000, 16'h0020)));
            endcase
            gaps_on = (phase != 5);
            for (int k = 0; k < 148; k++)
                random_item();
        end

        drain();
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
